FILE: design/pwmt_pkg.sv
// ----------------------------------------------------------------------------
// pwmt_pkg - shared definitions for the edge-aligned pwm timer
// Operation codes, register indexes and field widths used by the timer.
// ----------------------------------------------------------------------------
`default_nettype none

package pwmt_pkg;

    // default main counter width
    localparam int unsigned COUNT_WIDTH_DEF = 16;

    // fixed field widths of the streaming payload
    localparam int unsigned OPCODE_W   = 3;
    localparam int unsigned DATA_W     = 16;
    localparam int unsigned PSC_W      = 16;
    localparam int unsigned IN_TDATA_W = 24;
    localparam int unsigned OUT_TDATA_W = 24;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_BUF  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COMPARE_BUF = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LOW  = 2'd2;

    // item operation codes
    typedef enum logic [OPCODE_W-1:0] {
        OP_TICK        = 3'd0,
        OP_WR_PRESCALE = 3'd1,
        OP_WR_PERIOD   = 3'd2,
        OP_WR_COMPARE  = 3'd3,
        OP_WR_ENABLES  = 3'd4,
        OP_FORCE_UPD   = 3'd5
    } opcode_t;

endpackage : pwmt_pkg

`default_nettype wire

FILE: design/pwm_timer_with_preload_unit.sv
// ----------------------------------------------------------------------------
// pwm_timer_with_preload_unit - edge-aligned pwm timer with preload registers
// Single channel up counter with prescaler, auto-reload and compare, driven
// by a stream of tick and register-access items.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one item per transfer, either a counter tick or a register
//   write (prescaler, period, compare, enables) or a forced update.
//   m_ channel: exactly one result per item: pin level, counter value and
//   an update flag, in item order.
//   cfg channel: writes the buffer-enable and polarity bits; cfg_ready is
//   always high, write only while no item is outstanding.
//   m_tvalid rises in the cycle after the input transfer. Throughput is one
//   item per cycle while s_tready is high: the counter state and the result
//   register both advance in the cycle an item is taken, so back-to-back
//   items need no gap. When the receiver stalls, the result holds in the
//   output register and s_tready drops only while that register is full and
//   not being drained. Reset (aresetn low, synchronous) clears counters and
//   compare/prescaler, sets the period to all ones, disables counting and
//   output, and empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pwm_timer_with_preload_unit #(
    parameter int unsigned COUNT_WIDTH = pwmt_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // input items
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [2:0] opcode, [18:3] write_data, [23:19] zero
    input  wire logic [pwmt_pkg::IN_TDATA_W-1:0]   s_tdata,
    // results
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [0] pwm_level, [16:1] count_value, [17] update_flag, [23:18] zero
    output logic [pwmt_pkg::OUT_TDATA_W-1:0]       m_tdata,
    // configuration writes
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [pwmt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic                              cfg_data
);

    import pwmt_pkg::*;

    // configuration bits
    logic period_buf_en_reg;
    logic compare_buf_en_reg;
    logic active_low_reg;

    // timer state
    logic [PSC_W-1:0]       psc_count_reg,   psc_count_next;
    logic [COUNT_WIDTH-1:0] main_count_reg,  main_count_next;
    logic [PSC_W-1:0]       psc_buf_reg,     psc_buf_next;
    logic [PSC_W-1:0]       psc_act_reg,     psc_act_next;
    logic [COUNT_WIDTH-1:0] period_buf_reg,  period_buf_next;
    logic [COUNT_WIDTH-1:0] period_act_reg,  period_act_next;
    logic [COUNT_WIDTH-1:0] compare_buf_reg, compare_buf_next;
    logic [COUNT_WIDTH-1:0] compare_act_reg, compare_act_next;
    logic                   run_en_reg,      run_en_next;
    logic                   out_en_reg,      out_en_next;

    // output register
    logic                   m_valid_reg;
    logic [OUT_TDATA_W-1:0] m_data_reg;

    // item decode
    opcode_t                opcode;
    logic [DATA_W-1:0]      wr_data;
    logic [COUNT_WIDTH-1:0] wr_data_cnt;
    logic                   in_xfer;
    logic                   upd;
    logic                   active;
    logic                   level;
    logic [DATA_W-1:0]      count_out;

    assign opcode      = opcode_t'(s_tdata[OPCODE_W-1:0]);
    assign wr_data     = s_tdata[OPCODE_W +: DATA_W];
    assign wr_data_cnt = COUNT_WIDTH'(wr_data);

    assign s_tready  = !m_valid_reg || m_tready;
    assign in_xfer   = s_tvalid && s_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign cfg_ready = 1'b1;

    // next timer state for the current item
    always_comb begin
        psc_count_next   = psc_count_reg;
        main_count_next  = main_count_reg;
        psc_buf_next     = psc_buf_reg;
        psc_act_next     = psc_act_reg;
        period_buf_next  = period_buf_reg;
        period_act_next  = period_act_reg;
        compare_buf_next = compare_buf_reg;
        compare_act_next = compare_act_reg;
        run_en_next      = run_en_reg;
        out_en_next      = out_en_reg;
        upd              = 1'b0;

        unique case (opcode)
            OP_TICK: begin
                if (run_en_reg) begin
                    if (psc_count_reg >= psc_act_reg) begin
                        psc_count_next = '0;
                        // zero period blocks the main counter
                        if (period_act_reg != '0) begin
                            if (main_count_reg == period_act_reg) begin
                                main_count_next  = '0;
                                psc_act_next     = psc_buf_reg;
                                period_act_next  = period_buf_reg;
                                compare_act_next = compare_buf_reg;
                                upd              = 1'b1;
                            end else begin
                                main_count_next = main_count_reg + 1'b1;
                            end
                        end
                    end else begin
                        psc_count_next = psc_count_reg + 1'b1;
                    end
                end
            end
            OP_WR_PRESCALE: begin
                psc_buf_next = wr_data;
            end
            OP_WR_PERIOD: begin
                period_buf_next = wr_data_cnt;
                if (!period_buf_en_reg) begin
                    period_act_next = wr_data_cnt;
                end
            end
            OP_WR_COMPARE: begin
                compare_buf_next = wr_data_cnt;
                if (!compare_buf_en_reg) begin
                    compare_act_next = wr_data_cnt;
                end
            end
            OP_WR_ENABLES: begin
                run_en_next = wr_data[0];
                out_en_next = wr_data[1];
            end
            OP_FORCE_UPD: begin
                main_count_next  = '0;
                psc_count_next   = '0;
                psc_act_next     = psc_buf_reg;
                period_act_next  = period_buf_reg;
                compare_act_next = compare_buf_reg;
                upd              = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // pwm mode 1 with polarity and output gate
    assign active    = main_count_next < compare_act_next;
    assign level     = out_en_next && (active != active_low_reg);
    assign count_out = DATA_W'(main_count_next);

    // timer state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            psc_count_reg   <= '0;
            main_count_reg  <= '0;
            psc_buf_reg     <= '0;
            psc_act_reg     <= '0;
            period_buf_reg  <= '1;
            period_act_reg  <= '1;
            compare_buf_reg <= '0;
            compare_act_reg <= '0;
            run_en_reg      <= 1'b0;
            out_en_reg      <= 1'b0;
        end else if (in_xfer) begin
            psc_count_reg   <= psc_count_next;
            main_count_reg  <= main_count_next;
            psc_buf_reg     <= psc_buf_next;
            psc_act_reg     <= psc_act_next;
            period_buf_reg  <= period_buf_next;
            period_act_reg  <= period_act_next;
            compare_buf_reg <= compare_buf_next;
            compare_act_reg <= compare_act_next;
            run_en_reg      <= run_en_next;
            out_en_reg      <= out_en_next;
        end
    end

    // configuration register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_buf_en_reg  <= 1'b0;
            compare_buf_en_reg <= 1'b0;
            active_low_reg     <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_PERIOD_BUF:  period_buf_en_reg  <= cfg_data;
                REG_COMPARE_BUF: compare_buf_en_reg <= cfg_data;
                REG_ACTIVE_LOW:  active_low_reg     <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_xfer) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            m_data_reg <= {{(OUT_TDATA_W - DATA_W - 2){1'b0}}, upd, count_out, level};
        end
    end

endmodule : pwm_timer_with_preload_unit

`default_nettype wire

FILE: tb/pwm_timer_checker.sv
// ----------------------------------------------------------------------------
// pwm_timer_checker - result predictor and scoreboard for the pwm timer
// Watches the item, result and configuration channels, keeps its own model
// of the timer state and compares each result with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module pwm_timer_checker (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    input  wire logic                              s_tready,
    // [2:0] opcode, [18:3] write_data, [23:19] zero
    input  wire logic [pwmt_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  wire logic                              m_tvalid,
    input  wire logic                              m_tready,
    // [0] pwm_level, [16:1] count_value, [17] update_flag, [23:18] zero
    input  wire logic [pwmt_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  wire logic                              cfg_valid,
    input  wire logic                              cfg_ready,
    input  wire logic [pwmt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic                              cfg_data,
    output int                                     fail_count,
    output int                                     pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import pwmt_pkg::*;

    localparam int unsigned CNT_W = COUNT_WIDTH_DEF;

    typedef struct packed {
        logic        level;
        logic [15:0] count;
        logic        upd;
    } pin_state_t;

    // model of the timer registers
    logic [PSC_W-1:0] psc_cnt;
    logic [CNT_W-1:0] main_cnt;
    logic [PSC_W-1:0] psc_shadow;
    logic [PSC_W-1:0] psc_live;
    logic [CNT_W-1:0] per_shadow;
    logic [CNT_W-1:0] per_live;
    logic [CNT_W-1:0] cmp_shadow;
    logic [CNT_W-1:0] cmp_live;
    logic             run_on;
    logic             out_on;
    logic             per_buf_en;
    logic             cmp_buf_en;
    logic             act_low;

    pin_state_t pin_q[$];

    assign pending = pin_q.size();

    function automatic void load_shadows();
        psc_live = psc_shadow;
        per_live = per_shadow;
        cmp_live = cmp_shadow;
    endfunction

    // one enabled tick; returns 1 on an overflow update
    function automatic logic advance_counter();
        if (psc_cnt >= psc_live) begin
            psc_cnt = '0;
        end else begin
            psc_cnt = psc_cnt + 1'b1;
            return 1'b0;
        end
        // zero period blocks the main counter
        if (per_live == '0) begin
            return 1'b0;
        end
        if (main_cnt == per_live) begin
            main_cnt = '0;
            psc_cnt  = '0;
            load_shadows();
            return 1'b1;
        end
        // above the period the counter rolls over silently
        main_cnt = main_cnt + 1'b1;
        return 1'b0;
    endfunction

    function automatic pin_state_t predict_pin(input logic [OPCODE_W-1:0] op,
                                               input logic [DATA_W-1:0] wdata);
        pin_state_t res;
        logic       upd;
        logic       active;
        upd = 1'b0;
        case (op)
            OP_TICK: begin
                if (run_on) begin
                    upd = advance_counter();
                end
            end
            OP_WR_PRESCALE: psc_shadow = wdata;
            OP_WR_PERIOD: begin
                per_shadow = CNT_W'(wdata);
                if (!per_buf_en) begin
                    per_live = per_shadow;
                end
            end
            OP_WR_COMPARE: begin
                cmp_shadow = CNT_W'(wdata);
                if (!cmp_buf_en) begin
                    cmp_live = cmp_shadow;
                end
            end
            OP_WR_ENABLES: begin
                run_on = wdata[0];
                out_on = wdata[1];
            end
            OP_FORCE_UPD: begin
                main_cnt = '0;
                psc_cnt  = '0;
                load_shadows();
                upd = 1'b1;
            end
            default: ;
        endcase
        active    = main_cnt < cmp_live;
        res.level = out_on ? (active ^ act_low) : 1'b0;
        res.count = 16'(main_cnt);
        res.upd   = upd;
        return res;
    endfunction

    // observe all three channels at each edge
    always @(posedge aclk) begin
        pin_state_t exp_pin;
        logic       got_level;
        logic [15:0] got_count;
        logic       got_upd;
        if (!aresetn) begin
            psc_cnt    = '0;
            main_cnt   = '0;
            psc_shadow = '0;
            psc_live   = '0;
            per_shadow = '1;
            per_live   = '1;
            cmp_shadow = '0;
            cmp_live   = '0;
            run_on     = 1'b0;
            out_on     = 1'b0;
            per_buf_en = 1'b0;
            cmp_buf_en = 1'b0;
            act_low    = 1'b0;
            fail_count = 0;
            pin_q.delete();
        end else begin
            // result transfer against the oldest prediction
            if (m_tvalid && m_tready) begin
                got_level = m_tdata[0];
                got_count = m_tdata[16:1];
                got_upd   = m_tdata[17];
                if (pin_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result level=%0b count=%0d upd=%0b",
                             $time, got_level, got_count, got_upd);
                end else begin
                    exp_pin = pin_q.pop_front();
                    if (got_level !== exp_pin.level) begin
                        fail_count++;
                        $display("%0t: pwm_level expected %0b actual %0b",
                                 $time, exp_pin.level, got_level);
                    end
                    if (got_count !== exp_pin.count) begin
                        fail_count++;
                        $display("%0t: count_value expected %0d actual %0d",
                                 $time, exp_pin.count, got_count);
                    end
                    if (got_upd !== exp_pin.upd) begin
                        fail_count++;
                        $display("%0t: update_flag expected %0b actual %0b",
                                 $time, exp_pin.upd, got_upd);
                    end
                end
            end
            // register write
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_PERIOD_BUF:  per_buf_en = cfg_data;
                    REG_COMPARE_BUF: cmp_buf_en = cfg_data;
                    REG_ACTIVE_LOW:  act_low    = cfg_data;
                    default: ;
                endcase
            end
            // item transfer
            if (s_tvalid && s_tready) begin
                pin_q.push_back(predict_pin(s_tdata[OPCODE_W-1:0],
                                            s_tdata[OPCODE_W +: DATA_W]));
            end
        end
    end

endmodule : pwm_timer_checker

`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb - stimulus top for the pwm timer with preload
// Drives directed and random tick and register-access items in bursts, varies
// the buffer and polarity settings between phases, stalls the result side and
// reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pwmt_pkg::*;

    localparam int LIMIT      = 2_000_000;
    localparam int LONG_HOLD  = 300;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_ITEMS = 180;
    localparam int ROLL_TICKS = 40;

    // opcodes outside the defined set, expected to be ignored
    localparam logic [OPCODE_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_SPARE_B = 3'd7;

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata   = '0;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_tdata;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic                    cfg_data  = 1'b0;

    int fail_count;
    int pending;
    int cycle_count = 0;
    bit hold_req    = 1'b0;
    int burst_left  = 0;

    pwm_timer_with_preload_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pwm_timer_checker i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // clock
    initial begin
        forever #1 aclk = ~aclk;
    end

    // run limit
    initial begin
        while (cycle_count < LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("pwm_timer_with_preload_unit verification failed");
        $finish;
    end

    // result side stalls: segments of random modes plus one long hold-off
    initial begin
        int  seg_left;
        int  mode;
        bit  hold_taken;
        seg_left   = 0;
        mode       = 0;
        hold_taken = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end
            if (seg_left == 0) begin
                mode     = $urandom_range(0, 3);
                seg_left = $urandom_range(8, 64);
            end
            seg_left--;
            case (mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= (seg_left % 3 == 0);
                default: m_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // offer one item and wait for its transfer; gaps fall between bursts
    task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [DATA_W-1:0] wdata);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W-OPCODE_W-DATA_W){1'b0}}, wdata, op};
        do begin
            @(posedge aclk);
        end while (!s_tready);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(32, 96)
                                                     : $urandom_range(0, 15);
        end
    endtask

    // stop offering and wait until every result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // one register write on the configuration channel
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_mode(input logic per_buf, input logic cmp_buf, input logic low);
        write_reg(REG_PERIOD_BUF, per_buf);
        write_reg(REG_COMPARE_BUF, cmp_buf);
        write_reg(REG_ACTIVE_LOW, low);
    endtask

    // small values keep overflows frequent; now and then a full-width one
    function automatic logic [DATA_W-1:0] pick_value(input int top_val);
        if ($urandom_range(0, 15) == 0) begin
            return DATA_W'($urandom);
        end
        return DATA_W'($urandom_range(0, top_val));
    endfunction

    // random item mix, mostly ticks with a running counter
    task automatic random_item();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 74) begin
            send_item(OP_TICK, DATA_W'($urandom));
        end else if (sel < 79) begin
            send_item(OP_WR_PRESCALE, ($urandom_range(0, 31) == 0) ? DATA_W'($urandom)
                                                                   : DATA_W'($urandom_range(0, 3)));
        end else if (sel < 85) begin
            send_item(OP_WR_PERIOD, pick_value(24));
        end else if (sel < 91) begin
            send_item(OP_WR_COMPARE, pick_value(28));
        end else if (sel < 95) begin
            // mostly run with output on, sometimes any combination
            send_item(OP_WR_ENABLES, ($urandom_range(0, 2) == 0) ? DATA_W'($urandom)
                                                                 : (DATA_W'($urandom) | 16'h0003));
        end else if (sel < 98) begin
            send_item(OP_FORCE_UPD, DATA_W'($urandom));
        end else begin
            send_item(($urandom_range(0, 1) == 0) ? OP_SPARE_A : OP_SPARE_B, DATA_W'($urandom));
        end
    endtask

    // main sequence
    initial begin
        int phase;
        int n;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part with all buffering off and normal polarity
        set_mode(1'b0, 1'b0, 1'b0);
        send_item(OP_SPARE_A, 16'hFFFF);
        send_item(OP_SPARE_B, 16'h0000);
        send_item(OP_TICK, 16'hFFFF);         // stopped tick
        send_item(OP_FORCE_UPD, 16'h0000);    // forced update while stopped
        send_item(OP_WR_PRESCALE, 16'hFFFF);  // prescaler waits for an update
        send_item(OP_WR_PERIOD, 16'h0000);    // zero period blocks the counter
        send_item(OP_WR_COMPARE, 16'h0002);
        send_item(OP_WR_ENABLES, 16'hFFFF);
        send_item(OP_TICK, 16'h0000);
        send_item(OP_TICK, 16'h5555);
        send_item(OP_WR_PRESCALE, 16'h0001);
        send_item(OP_WR_PERIOD, 16'h0003);
        send_item(OP_FORCE_UPD, 16'hAAAA);
        repeat (9) send_item(OP_TICK, DATA_W'($urandom));
        send_item(OP_WR_COMPARE, 16'h0005);   // compare above the period
        repeat (4) send_item(OP_TICK, DATA_W'($urandom));
        send_item(OP_WR_ENABLES, 16'h0001);   // output off, still running
        send_item(OP_TICK, 16'h0000);
        send_item(OP_WR_ENABLES, 16'h0000);
        drain();

        // random phases, settings change only while idle
        for (phase = 0; phase < RAND_PHASES; phase++) begin
            if (phase == 0) begin
                set_mode(1'b1, 1'b1, 1'b1);
            end else if (phase == 1) begin
                set_mode(1'b0, 1'b0, 1'b0);
            end else begin
                set_mode(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
            end
            // well-formed setup, then the random mix
            send_item(OP_WR_PRESCALE, DATA_W'($urandom_range(0, 3)));
            send_item(OP_WR_PERIOD, DATA_W'($urandom_range(1, 24)));
            send_item(OP_WR_COMPARE, DATA_W'($urandom_range(0, 28)));
            send_item(OP_FORCE_UPD, DATA_W'($urandom));
            send_item(OP_WR_ENABLES, 16'h0003);
            if (phase == 2) begin
                hold_req <= 1'b1;
            end
            for (n = 0; n < PHASE_ITEMS; n++) begin
                random_item();
            end
            drain();
        end

        // counter pushed above the period keeps counting up without an update
        set_mode(1'b0, 1'b1, 1'b0);
        send_item(OP_WR_PRESCALE, 16'h0000);
        send_item(OP_WR_PERIOD, 16'hFFFF);
        send_item(OP_WR_COMPARE, 16'h8000);
        send_item(OP_FORCE_UPD, 16'h0000);
        send_item(OP_WR_ENABLES, 16'h0003);
        repeat (3) send_item(OP_TICK, DATA_W'($urandom));
        send_item(OP_WR_PERIOD, 16'h0001);
        repeat (ROLL_TICKS) send_item(OP_TICK, DATA_W'($urandom));
        drain();
        repeat (8) @(posedge aclk);

        if (fail_count == 0 && pending == 0) begin
            $display("pwm_timer_with_preload_unit verification clean");
        end else begin
            $display("pwm_timer_with_preload_unit verification failed");
        end
        $finish;
    end

endmodule : tb

`default_nettype wire
